[design/rtna_pkg.sv]
`default_nettype none

package rtna_pkg;

  // Fixed field widths
  localparam int ValueWidth       = 32;
  localparam int CharWidth        = 7;
  localparam int BaseWidth        = 6;
  localparam int DigitWidth       = 6;
  localparam int DefaultValueBits = 32;

  // Radix limits and reset value
  localparam logic [BaseWidth-1:0] BaseMin   = 6'd2;
  localparam logic [BaseWidth-1:0] BaseMax   = 6'd36;
  localparam logic [BaseWidth-1:0] BaseReset = 6'd16;

  // ASCII anchors
  localparam logic [CharWidth-1:0] AsciiZero   = 7'd48;
  localparam logic [CharWidth-1:0] AsciiLetter = 7'd55;  // 'A' - 10
  localparam logic [DigitWidth-1:0] DigitMax   = 6'd35;
  localparam logic [DigitWidth-1:0] DigitTen   = 6'd10;

  // Micro-program counter and step addresses
  localparam int UpcWidth = 4;
  typedef logic [UpcWidth-1:0] upc_t;

  localparam upc_t StepIdle   = 4'd0;
  localparam upc_t StepZChk   = 4'd1;
  localparam upc_t StepDInit  = 4'd2;
  localparam upc_t StepDStep  = 4'd3;
  localparam upc_t StepStore  = 4'd4;
  localparam upc_t StepOneChk = 4'd5;
  localparam upc_t StepPad    = 4'd6;
  localparam upc_t StepZPad   = 4'd7;
  localparam upc_t StepRdSet  = 4'd8;
  localparam upc_t StepRead   = 4'd9;
  localparam upc_t StepEmit   = 4'd10;
  localparam upc_t StepTest   = 4'd11;
  localparam upc_t StepEnd    = 4'd12;

  // Datapath actions
  typedef enum logic [3:0] {
    ActNop,
    ActLoad,
    ActDivInit,
    ActDivStep,
    ActStore,
    ActPad,
    ActRdInit,
    ActRead,
    ActEmit
  } action_e;

  // Jump conditions
  typedef enum logic [3:0] {
    CondNever,
    CondAlways,
    CondNoInput,
    CondQZero,
    CondQNonzero,
    CondDivBusy,
    CondMulti,
    CondOutBusy,
    CondMore
  } cond_e;

  typedef struct packed {
    action_e action;
    cond_e   cond;
    upc_t    target;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic q_zero;
    logic div_busy;
    logic multi;
    logic out_busy;
    logic more;
  } status_t;

  // Control store
  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t w;
    unique case (upc)
      StepIdle:   w = '{ActLoad,    CondNoInput,  StepIdle};
      StepZChk:   w = '{ActNop,     CondQZero,    StepZPad};
      StepDInit:  w = '{ActDivInit, CondNever,    StepIdle};
      StepDStep:  w = '{ActDivStep, CondDivBusy,  StepDStep};
      StepStore:  w = '{ActStore,   CondQNonzero, StepDInit};
      StepOneChk: w = '{ActNop,     CondMulti,    StepRdSet};
      StepPad:    w = '{ActPad,     CondAlways,   StepRdSet};
      StepZPad:   w = '{ActPad,     CondAlways,   StepPad};
      StepRdSet:  w = '{ActRdInit,  CondNever,    StepIdle};
      StepRead:   w = '{ActRead,    CondNever,    StepIdle};
      StepEmit:   w = '{ActEmit,    CondOutBusy,  StepEmit};
      StepTest:   w = '{ActNop,     CondMore,     StepRead};
      StepEnd:    w = '{ActNop,     CondAlways,   StepIdle};
      default:    w = '{ActNop,     CondAlways,   StepIdle};
    endcase
    return w;
  endfunction

  // Digit value to ASCII, '0'-'9' then 'A'-'Z'
  function automatic logic [CharWidth-1:0] to_ascii(input logic [DigitWidth-1:0] digit);
    logic [DigitWidth-1:0] d;
    d = (digit > DigitMax) ? DigitMax : digit;
    if (d < DigitTen) begin
      return AsciiZero + {1'b0, d};
    end
    return AsciiLetter + {1'b0, d};
  endfunction

endpackage

`default_nettype wire

[design/rtna_useq.sv]
`default_nettype none

module rtna_useq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire rtna_pkg::status_t status_i,
  output rtna_pkg::action_e    action_o
);
  import rtna_pkg::*;

  upc_t   upc_q, upc_d;
  ucode_t uword;
  logic   take;

  assign uword    = ucode_rom(upc_q);
  assign action_o = uword.action;

  // Jump condition select
  always_comb begin
    unique case (uword.cond)
      CondNever:    take = 1'b0;
      CondAlways:   take = 1'b1;
      CondNoInput:  take = !status_i.in_valid;
      CondQZero:    take = status_i.q_zero;
      CondQNonzero: take = !status_i.q_zero;
      CondDivBusy:  take = status_i.div_busy;
      CondMulti:    take = status_i.multi;
      CondOutBusy:  take = status_i.out_busy;
      CondMore:     take = status_i.more;
      default:      take = 1'b0;
    endcase
  end

  assign upc_d = take ? uword.target : upc_q + upc_t'(1);

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[design/radix_number_to_ascii_top.sv]
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------
// in       | sink      | in_valid_i / in_stall_o | value_i[31:0]
// out      | source    | out_valid_o/ out_stall_i| character_o[6:0], last_char_o
// config   | sink      | number_base_we_i        | number_base_i[5:0]
//
// The bit-serial restoring divider (one quotient bit a cycle) computes the digits
// and dominates the time per item; a leading zero is padded in when only one
// digit is computed.
// Reset clears the sequencer, counters and output valid; radix resets to 16.
// A stalled output holds its character; the sequencer waits on that step.
// Input is taken only while the sequencer sits at its idle step.

module radix_number_to_ascii_top #(
  parameter int VALUE_BITS = rtna_pkg::DefaultValueBits
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              number_base_we_i,
  input  wire  [rtna_pkg::BaseWidth-1:0]   number_base_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [rtna_pkg::ValueWidth-1:0]  value_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [rtna_pkg::CharWidth-1:0]   character_o,
  output logic                             last_char_o
);
  import rtna_pkg::*;

  localparam int CntW  = $clog2(VALUE_BITS + 1);
  localparam int AddrW = $clog2(VALUE_BITS);

  action_e action;
  status_t status;

  logic [BaseWidth-1:0]  base_q, base_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DigitWidth-1:0] rem_q, rem_d;
  logic [AddrW-1:0]      bit_q, bit_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [AddrW-1:0]      idx_q, idx_d;
  logic                  done_q, done_d;
  logic [DigitWidth-1:0] rd_q;
  logic                  out_valid_q, out_valid_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic                  last_q, last_d;

  logic [DigitWidth-1:0] digit_mem [VALUE_BITS];

  logic [DigitWidth:0]   shifted;
  logic                  fits;
  logic [DigitWidth:0]   diff;
  logic                  out_xfer;
  logic                  out_busy;
  logic                  emit_go;
  logic                  wr_en;
  logic [DigitWidth-1:0] wr_data;

  // Sequencer
  rtna_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .action_o (action)
  );

  // Radix register with saturation
  always_comb begin
    base_d = base_q;
    if (number_base_we_i) begin
      priority if (number_base_i < BaseMin) begin
        base_d = BaseMin;
      end else if (number_base_i > BaseMax) begin
        base_d = BaseMax;
      end else begin
        base_d = number_base_i;
      end
    end
  end

  // Restoring divide step
  assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits    = shifted >= {1'b0, base_q};
  assign diff    = shifted - {1'b0, base_q};

  // Output slot handshake
  assign out_xfer = out_valid_q && !out_stall_i;
  assign out_busy = out_valid_q && out_stall_i;
  assign emit_go  = (action == ActEmit) && !out_busy;

  assign in_stall_o = (action != ActLoad);

  // Datapath
  always_comb begin
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    done_d      = done_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_xfer;
    wr_en       = 1'b0;
    wr_data     = rem_q;
    unique case (action)
      ActLoad: begin
        if (in_valid_i) begin
          quo_d = VALUE_BITS'(value_i);
          cnt_d = '0;
        end
      end
      ActDivInit: begin
        rem_d = '0;
        bit_d = '0;
      end
      ActDivStep: begin
        quo_d = {quo_q[VALUE_BITS-2:0], fits};
        rem_d = fits ? diff[DigitWidth-1:0] : shifted[DigitWidth-1:0];
        bit_d = bit_q + AddrW'(1);
      end
      ActStore: begin
        wr_en   = 1'b1;
        wr_data = rem_q;
        cnt_d   = cnt_q + CntW'(1);
      end
      ActPad: begin
        wr_en   = 1'b1;
        wr_data = '0;
        cnt_d   = cnt_q + CntW'(1);
      end
      ActRdInit: begin
        idx_d = AddrW'(cnt_q - CntW'(1));
      end
      ActEmit: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          char_d      = to_ascii(rd_q);
          last_d      = (idx_q == '0);
          done_d      = (idx_q == '0);
          idx_d       = idx_q - AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Flags for the sequencer
  assign status.in_valid = in_valid_i;
  assign status.q_zero   = (quo_q == '0);
  assign status.div_busy = (bit_q != AddrW'(VALUE_BITS - 1));
  assign status.multi    = (cnt_q >= CntW'(2));
  assign status.out_busy = out_busy;
  assign status.more     = !done_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BaseReset;
      quo_q       <= '0;
      cnt_q       <= '0;
      bit_q       <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      quo_q       <= quo_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Digit store, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_mem[cnt_q[AddrW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (action == ActRead) begin
      rd_q <= digit_mem[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

  // Checks
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(VALUE_BITS))
    else $error("digit count past store depth");

  a_base_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q >= BaseMin && base_q <= BaseMax)
    else $error("radix out of range");

  a_two_chars : assert property (@(posedge clk_i) disable iff (!rst_ni)
    action == ActRdInit |-> cnt_q >= CntW'(2))
    else $error("fewer than two characters queued");

  a_emit_idle_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    action == ActEmit |-> in_stall_o)
    else $error("input open while sending");

endmodule

`default_nettype wire
